// ===== rtl/core/erb_pkg.sv =====
// ============================================================================
// erb_pkg
// Shared constants, status codes and helpers of the epoch-to-RTC converter.
// ============================================================================
`default_nettype none

package erb_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NS_BAD   = 2'd1;
    localparam logic [1:0] ST_YEAR_BAD = 2'd2;

    localparam logic [31:0] NANO_LIMIT = 32'd1000000000;

    // 2000-01-01 and 2100-01-01 in Unix seconds
    localparam logic signed [63:0] SECS_FIRST = 64'sd946684800;
    localparam logic signed [63:0] SECS_END   = 64'sd4102444800;

    // day number of 2000-01-01
    localparam logic [15:0] DAY_2000 = 16'd10957;

    // reciprocals: floor(2^s / d), quotient low by at most one
    localparam logic [25:0] RCP_675  = 26'd50903316; // s = 35
    localparam logic [15:0] RCP_3600 = 16'd37282;    // s = 27
    localparam logic [15:0] RCP_1461 = 16'd45933;    // s = 26
    localparam logic [16:0] RCP_7    = 17'd74898;    // s = 19
    localparam logic [12:0] RCP_60   = 13'd4369;     // s = 18

    typedef logic [8:0] doy_t;

    // first day of year (0-based) of each month, one day later from March on in a leap year
    function automatic doy_t month_start(input logic [3:0] k, input logic leap);
        doy_t base;
        case (k)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && k >= 4'd2)
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // two BCD digits of a value below 100
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = 15'(v) * 15'd205;
        tens = p[14:11];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/erb_if.sv =====
// ============================================================================
// erb_in_if / erb_out_if
// Valid/ready channels carrying a time value in and the RTC registers out.
// ============================================================================
`default_nettype none

interface erb_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] unix_seconds;
    logic [31:0]        nanos;

    modport source (output valid, output unix_seconds, output nanos, input ready);
    modport sink   (input valid, input unix_seconds, input nanos, output ready);
endinterface

interface erb_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] second_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] hour_bcd;
    logic [5:0] day_bcd;
    logic [2:0] weekday;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
    logic [1:0] status;

    modport source (output valid, output second_bcd, output minute_bcd, output hour_bcd,
                    output day_bcd, output weekday, output month_bcd, output year_bcd,
                    output status, input ready);
    modport sink   (input valid, input second_bcd, input minute_bcd, input hour_bcd,
                    input day_bcd, input weekday, input month_bcd, input year_bcd,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/epoch_seconds_to_rtc_bcd.sv =====
// ============================================================================
// epoch_seconds_to_rtc_bcd
// Converts signed Unix seconds plus nanoseconds to seven BCD RTC registers.
// ============================================================================
// Usage: drive in_ch with a time value; each input beat yields exactly one
// beat on out_ch, in order. Status 1 flags nanos of one billion or more,
// status 2 a year outside 2000..2099; with non-zero status all register
// fields are zero.
// Throughput: one beat per cycle while out_ch is ready, set by the
// eight-stage pipeline (range check, 25x26 reciprocal multiply for the
// day split, corrections, clock and calendar splits, BCD packing).
// Each stage holds its own valid bit; a stage loads whenever it is empty
// or the stage after it moves, so bubbles close up while out_ch stalls
// and in_ch keeps taking beats until every stage is full.
// Reset clears all valid bits; there is no other state and no clearing
// pass.
// ============================================================================
`default_nettype none

module epoch_seconds_to_rtc_bcd (
    input  wire logic clk,
    input  wire logic rst_n,
    erb_in_if.sink    in_ch,
    erb_out_if.source out_ch
);
    import erb_pkg::*;

    logic [8:1] v_reg;
    logic [9:1] rdy;

    always_comb
    begin
        rdy[9] = out_ch.ready;
        for (int i = 8; i >= 1; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                v_reg[1] <= in_ch.valid;
            end
            for (int i = 2; i <= 8; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign in_ch.ready  = rdy[1];
    assign out_ch.valid = v_reg[8];

    // ---- stage 1: status checks
    logic [1:0]  s1_st_reg;
    logic [31:0] s1_secs_reg;
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            if (in_ch.nanos >= NANO_LIMIT)
            begin
                s1_st_reg <= ST_NS_BAD;
            end
            else if (in_ch.unix_seconds < SECS_FIRST || in_ch.unix_seconds >= SECS_END)
            begin
                s1_st_reg <= ST_YEAR_BAD;
            end
            else
            begin
                s1_st_reg <= ST_OK;
            end
            s1_secs_reg <= in_ch.unix_seconds[31:0];
        end
    end

    // ---- stage 2: (secs >> 7) / 675 by reciprocal
    logic [1:0]  s2_st_reg;
    logic [31:0] s2_secs_reg;
    logic [50:0] s2_prod_reg;
    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s2_st_reg   <= s1_st_reg;
            s2_secs_reg <= s1_secs_reg;
            s2_prod_reg <= 51'(s1_secs_reg[31:7]) * 51'(RCP_675);
        end
    end

    // ---- stage 3: correct day count, form second of day
    logic [15:0] s3_q;
    logic [25:0] s3_rr;
    logic [15:0] s3_days_next;
    logic [9:0]  s3_rem_next;
    always_comb
    begin
        s3_q  = s2_prod_reg[50:35];
        s3_rr = {1'b0, s2_secs_reg[31:7]} - 26'(s3_q) * 26'd675;
        if (s3_rr >= 26'd675)
        begin
            s3_days_next = s3_q + 16'd1;
            s3_rem_next  = 10'(s3_rr - 26'd675);
        end
        else
        begin
            s3_days_next = s3_q;
            s3_rem_next  = s3_rr[9:0];
        end
    end

    logic [1:0]  s3_st_reg;
    logic [15:0] s3_days_reg;
    logic [16:0] s3_sod_reg;
    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s3_st_reg   <= s2_st_reg;
            s3_days_reg <= s3_days_next;
            s3_sod_reg  <= {s3_rem_next, s2_secs_reg[6:0]};
        end
    end

    // ---- stage 4: estimate hour, four-year block and week quotient
    logic [15:0] s4_d0;
    logic [16:0] s4_days4;
    logic [32:0] s4_hprod;
    logic [31:0] s4_bprod;
    logic [33:0] s4_wprod;
    always_comb
    begin
        s4_d0    = s3_days_reg - DAY_2000;
        s4_days4 = {1'b0, s3_days_reg} + 17'd4;
        s4_hprod = 33'(s3_sod_reg) * 33'(RCP_3600);
        s4_bprod = 32'(s4_d0) * 32'(RCP_1461);
        s4_wprod = 34'(s4_days4) * 34'(RCP_7);
    end

    logic [1:0]  s4_st_reg;
    logic [16:0] s4_sod_reg;
    logic [15:0] s4_d0_reg;
    logic [16:0] s4_days4_reg;
    logic [5:0]  s4_hq_reg;
    logic [5:0]  s4_bq_reg;
    logic [14:0] s4_wq_reg;
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s4_st_reg    <= s3_st_reg;
            s4_sod_reg   <= s3_sod_reg;
            s4_d0_reg    <= s4_d0;
            s4_days4_reg <= s4_days4;
            s4_hq_reg    <= s4_hprod[32:27];
            s4_bq_reg    <= s4_bprod[31:26];
            s4_wq_reg    <= s4_wprod[33:19];
        end
    end

    // ---- stage 5: correct the three quotients
    logic [16:0] s5_hr;
    logic [15:0] s5_br;
    logic [16:0] s5_wr;
    logic [4:0]  s5_hour_next;
    logic [11:0] s5_hrem_next;
    logic [4:0]  s5_blk_next;
    logic [10:0] s5_brem_next;
    logic [2:0]  s5_wd_next;
    always_comb
    begin
        s5_hr = s4_sod_reg - 17'(s4_hq_reg) * 17'd3600;
        s5_br = s4_d0_reg - 16'(s4_bq_reg) * 16'd1461;
        s5_wr = s4_days4_reg - 17'(s4_wq_reg) * 17'd7;
        if (s5_hr >= 17'd3600)
        begin
            s5_hour_next = 5'(s4_hq_reg + 6'd1);
            s5_hrem_next = 12'(s5_hr - 17'd3600);
        end
        else
        begin
            s5_hour_next = s4_hq_reg[4:0];
            s5_hrem_next = s5_hr[11:0];
        end
        if (s5_br >= 16'd1461)
        begin
            s5_blk_next  = 5'(s4_bq_reg + 6'd1);
            s5_brem_next = 11'(s5_br - 16'd1461);
        end
        else
        begin
            s5_blk_next  = s4_bq_reg[4:0];
            s5_brem_next = s5_br[10:0];
        end
        if (s5_wr >= 17'd7)
        begin
            s5_wd_next = 3'(s5_wr - 17'd7);
        end
        else
        begin
            s5_wd_next = s5_wr[2:0];
        end
    end

    logic [1:0]  s5_st_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_hrem_reg;
    logic [4:0]  s5_blk_reg;
    logic [10:0] s5_brem_reg;
    logic [2:0]  s5_wd_reg;
    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            s5_st_reg   <= s4_st_reg;
            s5_hour_reg <= s5_hour_next;
            s5_hrem_reg <= s5_hrem_next;
            s5_blk_reg  <= s5_blk_next;
            s5_brem_reg <= s5_brem_next;
            s5_wd_reg   <= s5_wd_next;
        end
    end

    // ---- stage 6: minute estimate, year within the four-year block
    // The first year of each block is the leap year (2000 counts as leap).
    logic [29:0] s6_mprod;
    logic [10:0] s6_t;
    logic [1:0]  s6_yo;
    logic [8:0]  s6_doy_next;
    always_comb
    begin
        s6_mprod = 30'(s5_hrem_reg) * 30'(RCP_60);
        s6_t     = s5_brem_reg - 11'd366;
        if (s5_brem_reg < 11'd366)
        begin
            s6_yo       = 2'd0;
            s6_doy_next = s5_brem_reg[8:0];
        end
        else if (s6_t < 11'd365)
        begin
            s6_yo       = 2'd1;
            s6_doy_next = s6_t[8:0];
        end
        else if (s6_t < 11'd730)
        begin
            s6_yo       = 2'd2;
            s6_doy_next = 9'(s6_t - 11'd365);
        end
        else
        begin
            s6_yo       = 2'd3;
            s6_doy_next = 9'(s6_t - 11'd730);
        end
    end

    logic [1:0]  s6_st_reg;
    logic [4:0]  s6_hour_reg;
    logic [11:0] s6_hrem_reg;
    logic [5:0]  s6_mq_reg;
    logic [8:0]  s6_doy_reg;
    logic        s6_leap_reg;
    logic [6:0]  s6_year_reg;
    logic [2:0]  s6_wd_reg;
    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            s6_st_reg   <= s5_st_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_hrem_reg <= s5_hrem_reg;
            s6_mq_reg   <= s6_mprod[23:18];
            s6_doy_reg  <= s6_doy_next;
            s6_leap_reg <= (s6_yo == 2'd0);
            s6_year_reg <= 7'(s5_blk_reg) * 7'd4 + 7'(s6_yo);
            s6_wd_reg   <= s5_wd_reg;
        end
    end

    // ---- stage 7: minute and second, month and day
    logic [11:0] s7_mr;
    logic [5:0]  s7_min_next;
    logic [5:0]  s7_sec_next;
    logic [3:0]  s7_mon_next;
    logic [4:0]  s7_day_next;
    doy_t        s7_start;
    always_comb
    begin
        s7_mr = s6_hrem_reg - 12'(s6_mq_reg) * 12'd60;
        if (s7_mr >= 12'd60)
        begin
            s7_min_next = s6_mq_reg + 6'd1;
            s7_sec_next = 6'(s7_mr - 12'd60);
        end
        else
        begin
            s7_min_next = s6_mq_reg;
            s7_sec_next = s7_mr[5:0];
        end
        s7_mon_next = 4'd0;
        s7_day_next = s6_doy_reg[4:0];
        for (int k = 1; k < 12; k++)
        begin
            s7_start = month_start(4'(k), s6_leap_reg);
            if (s6_doy_reg >= s7_start)
            begin
                s7_mon_next = 4'(k);
                s7_day_next = 5'(s6_doy_reg - s7_start);
            end
        end
    end

    logic [1:0] s7_st_reg;
    logic [4:0] s7_hour_reg;
    logic [5:0] s7_min_reg;
    logic [5:0] s7_sec_reg;
    logic [3:0] s7_mon_reg;
    logic [4:0] s7_day_reg;
    logic [6:0] s7_year_reg;
    logic [2:0] s7_wd_reg;
    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            s7_st_reg   <= s6_st_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_min_reg  <= s7_min_next;
            s7_sec_reg  <= s7_sec_next;
            s7_mon_reg  <= s7_mon_next;
            s7_day_reg  <= s7_day_next;
            s7_year_reg <= s6_year_reg;
            s7_wd_reg   <= s6_wd_reg;
        end
    end

    // ---- stage 8: BCD packing, zero the fields on error
    logic [7:0] b_sec;
    logic [7:0] b_min;
    logic [7:0] b_hour;
    logic [7:0] b_day;
    logic [7:0] b_mon;
    logic [7:0] b_year;
    logic       ok;
    always_comb
    begin
        b_sec  = to_bcd({1'b0, s7_sec_reg});
        b_min  = to_bcd({1'b0, s7_min_reg});
        b_hour = to_bcd({2'b0, s7_hour_reg});
        b_day  = to_bcd(7'(s7_day_reg) + 7'd1);
        b_mon  = to_bcd(7'(s7_mon_reg) + 7'd1);
        b_year = to_bcd(s7_year_reg);
        ok     = (s7_st_reg == ST_OK);
    end

    logic [6:0] o_sec_reg;
    logic [6:0] o_min_reg;
    logic [5:0] o_hour_reg;
    logic [5:0] o_day_reg;
    logic [2:0] o_wd_reg;
    logic [4:0] o_mon_reg;
    logic [7:0] o_year_reg;
    logic [1:0] o_st_reg;
    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            o_sec_reg  <= ok ? b_sec[6:0]  : 7'd0;
            o_min_reg  <= ok ? b_min[6:0]  : 7'd0;
            o_hour_reg <= ok ? b_hour[5:0] : 6'd0;
            o_day_reg  <= ok ? b_day[5:0]  : 6'd0;
            o_wd_reg   <= ok ? s7_wd_reg   : 3'd0;
            o_mon_reg  <= ok ? b_mon[4:0]  : 5'd0;
            o_year_reg <= ok ? b_year      : 8'd0;
            o_st_reg   <= s7_st_reg;
        end
    end

    assign out_ch.second_bcd = o_sec_reg;
    assign out_ch.minute_bcd = o_min_reg;
    assign out_ch.hour_bcd   = o_hour_reg;
    assign out_ch.day_bcd    = o_day_reg;
    assign out_ch.weekday    = o_wd_reg;
    assign out_ch.month_bcd  = o_mon_reg;
    assign out_ch.year_bcd   = o_year_reg;
    assign out_ch.status     = o_st_reg;

endmodule

`default_nettype wire

// ===== rtl/core/erb_checker.sv =====
// ============================================================================
// erb_checker
// Port-level checks on the result channel of the epoch-to-RTC converter.
// ============================================================================
`default_nettype none

module erb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [6:0] second_bcd,
    input wire logic [5:0] day_bcd,
    input wire logic [2:0] weekday,
    input wire logic [4:0] month_bcd,
    input wire logic [7:0] year_bcd,
    input wire logic [1:0] status
);
    import erb_pkg::*;

    // error beats carry all-zero register fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
            (second_bcd == 7'd0 && day_bcd == 6'd0 && weekday == 3'd0 &&
             month_bcd == 5'd0 && year_bcd == 8'd0))
        else $error("error beat with non-zero fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_NS_BAD || status == ST_YEAR_BAD))
        else $error("undefined status code");

    // good beats carry a real calendar date
    a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |->
            (month_bcd != 5'd0 && day_bcd != 6'd0 && weekday != 3'd7 &&
             second_bcd[3:0] <= 4'd9 && year_bcd[7:4] <= 4'd9))
        else $error("ok beat with impossible date");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(day_bcd)))
        else $error("stalled result changed");

endmodule

bind epoch_seconds_to_rtc_bcd erb_checker u_erb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .second_bcd (out_ch.second_bcd),
    .day_bcd    (out_ch.day_bcd),
    .weekday    (out_ch.weekday),
    .month_bcd  (out_ch.month_bcd),
    .year_bcd   (out_ch.year_bcd),
    .status     (out_ch.status)
);

`default_nettype wire
